### sv/stb_pkg.sv
// Shared types, codes and constants of the software timer bank.
`timescale 1ns / 1ps
package stb_pkg;

  localparam int TIMER_COUNT = 8;
  localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  localparam int US_PER_MS   = 1000;
  // floor(2^41 / 1000): the quotient estimate is at most one below the truth
  localparam logic [31:0] RECIP_MS = 32'd2199023255;
  localparam int RECIP_SHIFT = 41;
  localparam int QUOT_W      = 64 - RECIP_SHIFT;

  localparam logic [1:0] MODE_ONESHOT = 2'd0;
  localparam logic [1:0] MODE_CYCLIC  = 2'd1;

  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_STOP   = 2'd1,
    CMD_GET    = 2'd2,
    CMD_UPDATE = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    TS_STOPPED = 2'd0,
    TS_RUNNING = 2'd1,
    TS_TIMEOUT = 2'd2,
    TS_NONE    = 2'd3
  } tstate_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ASUM,
    ST_AMUL,
    ST_AREM,
    ST_AFIX,
    ST_REPLY,
    ST_WRD,
    ST_WEVAL,
    ST_WCMP,
    ST_WNEXT,
    ST_WEND
  } ctrl_state_t;

  typedef struct packed {
    logic        cyclic;
    logic [30:0] period;
    logic [31:0] due_ms;
    logic [9:0]  due_us;
  } timer_entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    latch;
    logic    ok_ld;
    logic    mem_rd;
    logic    sum_ld;
    logic    mul_ld;
    logic    rem_ld;
    logic    arm_wr;
    logic    diff_ld;
    logic    rs_wr;
    tstate_t rs_val;
    logic    reply_ld;
    logic    pend_push;
    logic    push_last;
    logic    pend_set;
    logic    pend_clr;
    logic    idx_clr;
    logic    idx_inc;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    cmd_code_t cmd;
    logic      start_ok;
    tstate_t   rs_cur;
    logic      cyc_rd;
    logic      expire;
    logic      idx_last;
    logic      pend_valid;
    logic      out_free;
  } ctrl_sts_t;

endpackage

### sv/stb_in_if.sv
// Input channel of the timer bank: command transactions.
`timescale 1ns / 1ps
interface stb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  timer_id;
  logic [1:0]  mode;
  logic [30:0] period_us;
  logic [31:0] now_ms;
  logic [9:0]  now_us;

  modport source (output valid, output command, output timer_id, output mode,
                  output period_us, output now_ms, output now_us, input ready);
  modport sink (input valid, input command, input timer_id, input mode,
                input period_us, input now_ms, input now_us, output ready);
endinterface

### sv/stb_out_if.sv
// Result channel of the timer bank: replies and expiry events.
`timescale 1ns / 1ps
interface stb_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       ok;
  logic [1:0] timer_state;
  logic [5:0] expired_id;
  logic       last;

  modport source (output valid, output kind, output ok, output timer_state,
                  output expired_id, output last, input ready);
  modport sink (input valid, input kind, input ok, input timer_state,
                input expired_id, input last, output ready);
endinterface

### sv/stb_ctrl.sv
// Sequencing state machine of the timer bank.
`timescale 1ns / 1ps
module stb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output stb_pkg::ctrl_cmd_t cmd,
  input  stb_pkg::ctrl_sts_t sts
);
  import stb_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rs_val = TS_STOPPED;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch   = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.cmd)
          CMD_START: begin
            cmd.ok_ld = 1'b1;
            state_nxt = sts.start_ok ? ST_ASUM : ST_REPLY;
          end
          CMD_UPDATE: state_nxt = ST_WRD;
          default:    state_nxt = ST_REPLY;
        endcase
      end
      // Arm: now plus period, split into ms and us
      ST_ASUM: begin
        cmd.sum_ld = 1'b1;
        state_nxt  = ST_AMUL;
      end
      ST_AMUL: begin
        cmd.mul_ld = 1'b1;
        state_nxt  = ST_AREM;
      end
      ST_AREM: begin
        cmd.rem_ld = 1'b1;
        state_nxt  = ST_AFIX;
      end
      ST_AFIX: begin
        cmd.arm_wr = 1'b1;
        state_nxt  = (sts.cmd == CMD_START) ? ST_REPLY : ST_WNEXT;
      end
      ST_REPLY: begin
        if (sts.out_free) begin
          cmd.reply_ld = 1'b1;
          if (sts.cmd == CMD_STOP) begin
            cmd.rs_wr  = 1'b1;
            cmd.rs_val = TS_STOPPED;
          end
          state_nxt = ST_IDLE;
        end
      end
      // Update walk, one timer at a time
      ST_WRD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_WEVAL;
      end
      ST_WEVAL: begin
        case (sts.rs_cur)
          TS_RUNNING: begin
            cmd.diff_ld = 1'b1;
            state_nxt   = ST_WCMP;
          end
          TS_TIMEOUT: begin
            if (sts.cyc_rd) begin
              state_nxt = ST_ASUM;
            end else begin
              cmd.rs_wr  = 1'b1;
              cmd.rs_val = TS_STOPPED;
              state_nxt  = ST_WNEXT;
            end
          end
          default: state_nxt = ST_WNEXT;
        endcase
      end
      ST_WCMP: begin
        if (!sts.expire) begin
          state_nxt = ST_WNEXT;
        end else if (!sts.pend_valid || sts.out_free) begin
          // hand the held expiry on, hold the new one back
          cmd.pend_push = sts.pend_valid;
          cmd.rs_wr     = 1'b1;
          cmd.rs_val    = TS_TIMEOUT;
          cmd.pend_set  = 1'b1;
          state_nxt     = ST_WNEXT;
        end
      end
      ST_WNEXT: begin
        if (sts.idx_last) begin
          state_nxt = ST_WEND;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_WRD;
        end
      end
      ST_WEND: begin
        if (!sts.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.pend_push = 1'b1;
          cmd.push_last = 1'b1;
          cmd.pend_clr  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### sv/stb_datapath.sv
// Timer store, time arithmetic and result register of the timer bank.
`timescale 1ns / 1ps
module stb_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_timer_id,
  input  logic [1:0]         in_mode,
  input  logic [30:0]        in_period_us,
  input  logic [31:0]        in_now_ms,
  input  logic [9:0]         in_now_us,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_kind,
  output logic               out_ok,
  output logic [1:0]         out_timer_state,
  output logic [5:0]         out_expired_id,
  output logic               out_last,
  input  stb_pkg::ctrl_cmd_t cmd,
  output stb_pkg::ctrl_sts_t sts
);
  import stb_pkg::*;

  // Latched transaction
  cmd_code_t   cmd_r;
  logic [7:0]  id_r;
  logic [1:0]  mode_r;
  logic [30:0] per_r;
  logic [31:0] now_ms_r;
  logic [9:0]  now_us_r;

  tstate_t      rs_r [TIMER_COUNT];
  timer_entry_t mem [TIMER_COUNT];
  timer_entry_t rd_r;

  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  addr;
  logic              good;
  logic              addr_good;
  logic              is_start;
  tstate_t           rs_cur;

  logic [31:0]       sum_r;
  logic [63:0]       prod_r;
  logic [QUOT_W-1:0] q_r;
  logic [10:0]       rem_r;
  logic [QUOT_W-1:0] q_fix;
  logic [10:0]       rem_fix;
  logic [31:0]       rem_raw;
  logic [31:0]       diff_r;
  logic [31:0]       diff_full;
  timer_entry_t      entry_wr;
  logic              ok_r;

  logic              pend_valid_r;
  logic [IDX_W-1:0]  pend_id_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic              out_ok_r;
  logic [1:0]        out_state_r;
  logic [5:0]        out_id_r;
  logic              out_last_r;
  logic              out_free;
  logic              reply_ok;
  tstate_t           reply_state;

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r    <= cmd_code_t'(in_command);
      id_r     <= in_timer_id;
      mode_r   <= in_mode;
      per_r    <= in_period_us;
      now_ms_r <= in_now_ms;
      now_us_r <= in_now_us;
    end
  end

  // Address: walk index during update, timer id otherwise
  assign good      = (id_r < 8'(TIMER_COUNT));
  assign is_start  = (cmd_r == CMD_START);
  assign addr      = (cmd_r == CMD_UPDATE) ? idx_r :
                     (good ? id_r[IDX_W-1:0] : '0);
  assign addr_good = (cmd_r == CMD_UPDATE) || good;
  assign rs_cur    = rs_r[addr];

  // Walk index
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // Run state per timer, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TIMER_COUNT; i++) begin
        rs_r[i] <= TS_STOPPED;
      end
    end else if (cmd.arm_wr && addr_good) begin
      rs_r[addr] <= TS_RUNNING;
    end else if (cmd.rs_wr && addr_good) begin
      rs_r[addr] <= cmd.rs_val;
    end
  end

  // Start check result, kept for the reply
  always_ff @(posedge clk) begin
    if (cmd.ok_ld) begin
      ok_r <= sts.start_ok;
    end
  end

  // Arm stage 1: microsecond sum
  always_ff @(posedge clk) begin
    if (cmd.sum_ld) begin
      sum_r <= 32'(now_us_r) + 32'(is_start ? per_r : rd_r.period);
    end
  end

  // Arm stage 2: multiply by the reciprocal of 1000
  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      prod_r <= 64'(sum_r) * 64'(RECIP_MS);
    end
  end

  // Arm stage 3: quotient estimate and remainder below 2000
  assign rem_raw = sum_r - 32'(prod_r[63:RECIP_SHIFT]) * 32'(US_PER_MS);

  always_ff @(posedge clk) begin
    if (cmd.rem_ld) begin
      q_r   <= prod_r[63:RECIP_SHIFT];
      rem_r <= rem_raw[10:0];
    end
  end

  // Arm stage 4: one correction step, then write the entry
  always_comb begin
    if (rem_r >= 11'(US_PER_MS)) begin
      q_fix   = q_r + 1'b1;
      rem_fix = rem_r - 11'(US_PER_MS);
    end else begin
      q_fix   = q_r;
      rem_fix = rem_r;
    end
    entry_wr.cyclic = is_start ? (mode_r == MODE_CYCLIC) : rd_r.cyclic;
    entry_wr.period = is_start ? per_r : rd_r.period;
    entry_wr.due_ms = now_ms_r + 32'(q_fix);
    entry_wr.due_us = rem_fix[9:0];
  end

  // Timer store
  always_ff @(posedge clk) begin
    if (cmd.arm_wr && addr_good) begin
      mem[addr] <= entry_wr;
    end
    if (cmd.mem_rd) begin
      rd_r <= mem[addr];
    end
  end

  // Due check: scaled millisecond difference, then microsecond terms
  always_ff @(posedge clk) begin
    if (cmd.diff_ld) begin
      diff_r <= (now_ms_r - rd_r.due_ms) * 32'(US_PER_MS);
    end
  end

  assign diff_full = diff_r + 32'(now_us_r) - 32'(rd_r.due_us);

  // Held expiry, so that the final one can carry last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.pend_set) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.pend_clr) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_set) begin
      pend_id_r <= idx_r;
    end
  end

  // Reply fields
  always_comb begin
    case (cmd_r)
      CMD_START: reply_ok = ok_r;
      CMD_STOP:  reply_ok = good;
      default:   reply_ok = 1'b0;
    endcase
    if (!good) begin
      reply_state = TS_NONE;
    end else if (cmd_r == CMD_STOP) begin
      reply_state = TS_STOPPED;
    end else begin
      reply_state = rs_cur;
    end
  end

  // Result register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.reply_ld || cmd.pend_push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reply_ld) begin
      out_kind_r  <= KIND_REPLY;
      out_ok_r    <= reply_ok;
      out_state_r <= reply_state;
      out_id_r    <= '0;
      out_last_r  <= 1'b1;
    end else if (cmd.pend_push) begin
      out_kind_r  <= KIND_EXPIRY;
      out_ok_r    <= 1'b0;
      out_state_r <= TS_TIMEOUT;
      out_id_r    <= 6'(pend_id_r);
      out_last_r  <= cmd.push_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_ok          = out_ok_r;
  assign out_timer_state = out_state_r;
  assign out_expired_id  = out_id_r;
  assign out_last        = out_last_r;

  // Status to the controller
  assign sts.cmd        = cmd_r;
  assign sts.start_ok   = good && (mode_r == MODE_ONESHOT || mode_r == MODE_CYCLIC) &&
                          (rs_cur == TS_STOPPED);
  assign sts.rs_cur     = rs_cur;
  assign sts.cyc_rd     = rd_r.cyclic;
  assign sts.expire     = !diff_full[31];
  assign sts.idx_last   = (idx_r == IDX_W'(TIMER_COUNT - 1));
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = out_free;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.reply_ld || cmd.pend_push) |-> out_free)
    else $error("result loaded while the result register is held");

  a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.reply_ld && cmd.pend_push))
    else $error("reply and expiry loaded together");

  a_arm_good: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.arm_wr |-> addr_good)
    else $error("timer armed at a bad id");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem_ld |=> (rem_r < 11'd2000))
    else $error("quotient estimate off by more than one");

  a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pend_push |-> pend_valid_r)
    else $error("expiry pushed with nothing held");
`endif

endmodule

### sv/soft_timer_bank.sv
// Top level of the software timer bank: controller plus datapath.
// Update walks the timers in order, one at a time; a cyclic re-arm reuses the shared arm
// pipeline, and the timer store is read and written through one address.
// One transaction is worked at a time; the next is taken once the previous is done.
// Reset (synchronous, active low) stops every timer at once; no clearing pass.
`timescale 1ns / 1ps
module soft_timer_bank (
  input  logic     clk,
  input  logic     rst_n,
  stb_in_if.sink   in_ch,
  stb_out_if.source out_ch
);
  import stb_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  // Sequencer
  stb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Store, arithmetic and result register
  stb_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_ch.command),
    .in_timer_id     (in_ch.timer_id),
    .in_mode         (in_ch.mode),
    .in_period_us    (in_ch.period_us),
    .in_now_ms       (in_ch.now_ms),
    .in_now_us       (in_ch.now_us),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_kind        (out_ch.kind),
    .out_ok          (out_ch.ok),
    .out_timer_state (out_ch.timer_state),
    .out_expired_id  (out_ch.expired_id),
    .out_last        (out_ch.last),
    .cmd             (cmd),
    .sts             (sts)
  );

  assign in_ch.ready = in_ready;

endmodule
